// ----- rtl/wsd_pkg.sv -----
package wsd_pkg;

  // Parser phase, one-hot
  typedef enum logic [8:0] {
    PH_HDR0      = 9'b0_0000_0001,
    PH_HDR1      = 9'b0_0000_0010,
    PH_EXTHI_M   = 9'b0_0000_0100,
    PH_EXTHI_NOM = 9'b0_0000_1000,
    PH_EXTLO_M   = 9'b0_0001_0000,
    PH_EXTLO_NOM = 9'b0_0010_0000,
    PH_MASK      = 9'b0_0100_0000,
    PH_DATA      = 9'b0_1000_0000,
    PH_HALT      = 9'b1_0000_0000
  } phase_t;

  // Result event codes
  localparam logic [1:0] EV_BYTE  = 2'd0;
  localparam logic [1:0] EV_EMPTY = 2'd1;
  localparam logic [1:0] EV_CLOSE = 2'd2;
  localparam logic [1:0] EV_ERROR = 2'd3;

  // Input beat kinds
  localparam logic KIND_DATA    = 1'b0;
  localparam logic KIND_RESTART = 1'b1;

  // Frame opcodes and length codes
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [6:0] LEN_EXT16 = 7'd126;
  localparam logic [6:0] LEN_EXT64 = 7'd127;

  // One result beat
  typedef struct packed {
    logic [1:0] event_res;
    logic [7:0] payload_byte;
    logic       last;
  } res_t;

endpackage

// ----- rtl/wsd_ifs.sv -----
// Input byte channel
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink   (input valid, input kind, input data_byte, output ready);
endinterface

// Result channel
interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] event_res;
  logic [7:0] payload_byte;
  logic       last;

  modport source (output valid, output event_res, output payload_byte, output last,
                  input ready);
  modport sink   (input valid, input event_res, input payload_byte, input last,
                  output ready);
endinterface

// ----- rtl/wsd_parser.sv -----
module wsd_parser #(
  parameter int MAX_PAYLOAD = 511
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          beat_fire,
  input  logic          kind,
  input  logic [7:0]    data_byte,
  output logic          res_valid,
  output wsd_pkg::res_t res
);
  import wsd_pkg::*;

  localparam int          LEN_W   = $clog2(MAX_PAYLOAD + 1);
  localparam logic [15:0] MAX_LEN = 16'(MAX_PAYLOAD);

  phase_t           phase_r,   phase_nxt;
  logic [3:0]       opcode_r,  opcode_nxt;
  logic [7:0]       len_hi_r,  len_hi_nxt;
  logic [LEN_W-1:0] len_r,     len_nxt;
  logic [LEN_W-1:0] idx_r,     idx_nxt;
  logic [7:0]       mask_r [4];
  logic             mask_we;

  logic [6:0]       len7;
  logic [15:0]      len16;
  logic [LEN_W:0]   idx_inc;
  logic             data_end;

  assign len7     = data_byte[6:0];
  assign len16    = {len_hi_r, data_byte};
  assign idx_inc  = {1'b0, idx_r} + 1'b1;
  assign data_end = idx_inc >= {1'b0, len_r};

  // Next state and result for one beat
  always_comb begin
    phase_nxt  = phase_r;
    opcode_nxt = opcode_r;
    len_hi_nxt = len_hi_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    mask_we    = 1'b0;
    res_valid  = 1'b0;
    res        = '0;

    if (kind == KIND_RESTART) begin
      phase_nxt  = PH_HDR0;
      opcode_nxt = '0;
      len_hi_nxt = '0;
      len_nxt    = '0;
      idx_nxt    = '0;
    end else begin
      unique case (phase_r)
        PH_HDR0: begin
          opcode_nxt = data_byte[3:0];
          phase_nxt  = PH_HDR1;
        end
        PH_HDR1: begin
          if (len7 == LEN_EXT64) begin
            phase_nxt     = PH_HALT;
            res_valid     = 1'b1;
            res.event_res = EV_ERROR;
          end else if (len7 == LEN_EXT16) begin
            phase_nxt = data_byte[7] ? PH_EXTHI_M : PH_EXTHI_NOM;
          end else if (!data_byte[7] || ({9'd0, len7} > MAX_LEN)) begin
            phase_nxt     = PH_HALT;
            res_valid     = 1'b1;
            res.event_res = EV_ERROR;
          end else begin
            len_nxt   = LEN_W'(len7);
            idx_nxt   = '0;
            phase_nxt = PH_MASK;
          end
        end
        PH_EXTHI_M, PH_EXTHI_NOM: begin
          len_hi_nxt = data_byte;
          phase_nxt  = (phase_r == PH_EXTHI_M) ? PH_EXTLO_M : PH_EXTLO_NOM;
        end
        PH_EXTLO_M, PH_EXTLO_NOM: begin
          if (phase_r == PH_EXTLO_NOM || len16 > MAX_LEN) begin
            phase_nxt     = PH_HALT;
            res_valid     = 1'b1;
            res.event_res = EV_ERROR;
          end else begin
            len_nxt   = len16[LEN_W-1:0];
            idx_nxt   = '0;
            phase_nxt = PH_MASK;
          end
        end
        PH_MASK: begin
          mask_we = 1'b1;
          if (idx_r[1:0] != 2'd3) begin
            idx_nxt = idx_inc[LEN_W-1:0];
          end else begin
            idx_nxt = '0;
            if (len_r != '0) begin
              phase_nxt = PH_DATA;
            end else if (opcode_r == OP_CLOSE) begin
              phase_nxt     = PH_HALT;
              res_valid     = 1'b1;
              res.event_res = EV_CLOSE;
            end else begin
              phase_nxt = PH_HDR0;
              if (opcode_r == OP_TEXT) begin
                res_valid     = 1'b1;
                res.event_res = EV_EMPTY;
              end
            end
          end
        end
        PH_DATA: begin
          idx_nxt = idx_inc[LEN_W-1:0];
          if (opcode_r == OP_TEXT) begin
            res_valid        = 1'b1;
            res.event_res    = EV_BYTE;
            res.payload_byte = data_byte ^ mask_r[idx_r[1:0]];
            res.last         = data_end;
            if (data_end) phase_nxt = PH_HDR0;
          end else if (data_end) begin
            if (opcode_r == OP_CLOSE) begin
              phase_nxt     = PH_HALT;
              res_valid     = 1'b1;
              res.event_res = EV_CLOSE;
            end else begin
              phase_nxt = PH_HDR0;
            end
          end
        end
        default: begin
          // halted until restart
        end
      endcase
    end
  end

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_HDR0;
      opcode_r <= '0;
      len_hi_r <= '0;
      len_r    <= '0;
      idx_r    <= '0;
    end else if (beat_fire) begin
      phase_r  <= phase_nxt;
      opcode_r <= opcode_nxt;
      len_hi_r <= len_hi_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Mask key bytes; cleared on reset and restart
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) mask_r[i] <= '0;
    end else if (beat_fire) begin
      if (kind == KIND_RESTART) begin
        for (int i = 0; i < 4; i++) mask_r[i] <= '0;
      end else if (mask_we) begin
        mask_r[idx_r[1:0]] <= data_byte;
      end
    end
  end

endmodule

// ----- rtl/wsd_out_skid.sv -----
module wsd_out_skid (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  wsd_pkg::res_t push_res,
  output logic          can_take,
  output logic          out_valid,
  output wsd_pkg::res_t out_res,
  input  logic          out_ready
);
  import wsd_pkg::*;

  logic main_v_r;
  logic skid_v_r;
  res_t main_r;
  res_t skid_r;
  logic pop;

  assign pop       = main_v_r & out_ready;
  assign can_take  = !skid_v_r;
  assign out_valid = main_v_r;
  assign out_res   = main_r;

  // Valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_v_r <= 1'b0;
      skid_v_r <= 1'b0;
    end else if (!main_v_r || pop) begin
      main_v_r <= skid_v_r | push;
      skid_v_r <= 1'b0;
    end else if (push) begin
      skid_v_r <= 1'b1;
    end
  end

  // Payload: main register refills from skid first to keep beat order
  always_ff @(posedge clk) begin
    if (!main_v_r || pop) begin
      main_r <= skid_v_r ? skid_r : push_res;
    end else if (push) begin
      skid_r <= push_res;
    end
  end

endmodule

// ----- rtl/websocket_client_frame_deframer_top.sv -----
// WebSocket client frame deframer.
// in_ch carries received bytes (kind = data) or a restart marker (kind = restart)
// with valid/ready; a beat moves when both are high. out_ch carries one result
// beat per event: unmasked text payload bytes (last on the frame's final byte),
// empty text frame, close received, or protocol error.
// Throughput: one input beat per cycle while the output buffer has room. With
// the output buffer empty, a result appears on out_ch the cycle after its input
// beat is accepted; beats that cause no result leave nothing on out_ch. The
// per-byte header/mask state machine sits between the input handshake and a
// two-entry output buffer.
// Reset (rst_n low, synchronous) puts the parser back to waiting for a frame's
// first header byte with mask key and lengths cleared, and empties the output
// buffer. After a close or error event all data beats are dropped until a
// restart beat. When the receiver stalls, in_ch.ready stays high until a second
// result is waiting in the buffer, so beats keep flowing until then; after that
// in_ch.ready stays low until out_ch takes a beat. MAX_PAYLOAD (125..65535)
// bounds the accepted frame length; longer frames raise a protocol error.
module websocket_client_frame_deframer_top #(
  parameter int MAX_PAYLOAD = 511
) (
  input logic       clk,
  input logic       rst_n,
  wsd_in_if.sink    in_ch,
  wsd_out_if.source out_ch
);
  import wsd_pkg::*;

  logic beat_fire;
  logic can_take;
  logic res_valid;
  res_t res;
  res_t out_res;

  assign in_ch.ready = can_take;
  assign beat_fire   = in_ch.valid & can_take;

  wsd_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .beat_fire (beat_fire),
    .kind      (in_ch.kind),
    .data_byte (in_ch.data_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_out_skid u_out_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (beat_fire & res_valid),
    .push_res  (res),
    .can_take  (can_take),
    .out_valid (out_ch.valid),
    .out_res   (out_res),
    .out_ready (out_ch.ready)
  );

  assign out_ch.event_res    = out_res.event_res;
  assign out_ch.payload_byte = out_res.payload_byte;
  assign out_ch.last         = out_res.last;

endmodule
